// ===== hw/rtl/ils_pkg.sv =====
`default_nettype none

package ils_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CountW   = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned ValueW   = 32;
  localparam int unsigned PosW     = 8;
  localparam int unsigned EntryW   = 9;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef struct packed {
    opcode_e                    opcode;
    logic signed [ValueW-1:0]   item_value;
    logic        [PosW-1:0]     position;
  } in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]   result_value;
    status_e                    status;
    logic        [EntryW-1:0]   entry_count;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/indexed_list_store.sv =====
`default_nettype none

// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+---------------------
// in       | input     | in_valid_i/in_ready_o | in_data_i  (in_t)
// out      | output    | out_valid_o/out_ready_i | out_data_o (out_t)
//
// one item per cycle unless the output stalls; the result appears in the
// output register in the cycle after the item is taken. every entry sits
// in its own cell, so a remove moves all later entries forward together.
// reset clears the count and the output valid; entry contents stay unset.
// a stalled output blocks input only while its register is still full.

module indexed_list_store (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire ils_pkg::in_t   in_data_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output ils_pkg::out_t       out_data_o
);

  logic [ils_pkg::CountW-1:0] count_q, count_d;
  logic                       out_valid_q, out_valid_d;
  ils_pkg::out_t              out_data_q, out_data_d;

  logic                       accept;
  logic                       full;
  logic                       pos_ok;
  logic [ils_pkg::EntryW-1:0] count_ext;
  logic [ils_pkg::EntryW-1:0] pos_ext;
  logic signed [ils_pkg::ValueW-1:0] sel_entry;

  ils_pkg::cell_ctrl_t         ctrl [ils_pkg::Capacity];
  logic signed [ils_pkg::ValueW-1:0] entry [ils_pkg::Capacity];
  logic signed [ils_pkg::ValueW-1:0] next_entry [ils_pkg::Capacity];

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign count_ext = ils_pkg::EntryW'(count_q);
  assign pos_ext   = ils_pkg::EntryW'(in_data_i.position);
  assign full      = (count_ext == ils_pkg::EntryW'(ils_pkg::Capacity));
  assign pos_ok    = (pos_ext < count_ext);
  assign sel_entry = entry[in_data_i.position[ils_pkg::IdxW-1:0]];

  for (genvar i = 0; i < ils_pkg::Capacity; i++) begin : g_cell
    assign ctrl[i].load = accept && (in_data_i.opcode == ils_pkg::OP_APPEND)
                          && (count_ext == ils_pkg::EntryW'(i));
    assign ctrl[i].shift = accept && (in_data_i.opcode == ils_pkg::OP_REMOVE)
                           && pos_ok && (ils_pkg::EntryW'(i) >= pos_ext)
                           && (ils_pkg::EntryW'(i + 1) < count_ext);

    if (i + 1 < ils_pkg::Capacity) begin : g_link
      assign next_entry[i] = entry[i + 1];
    end else begin : g_tail
      assign next_entry[i] = '0;
    end

    ils_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl[i]),
      .load_value_i (in_data_i.item_value),
      .next_entry_i (next_entry[i]),
      .entry_o      (entry[i])
    );
  end

  always_comb begin
    count_d     = count_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (accept) begin
      out_valid_d             = 1'b1;
      out_data_d.result_value = '0;
      out_data_d.status       = ils_pkg::ST_OK;
      case (in_data_i.opcode)
        ils_pkg::OP_APPEND: begin
          if (full) begin
            out_data_d.status = ils_pkg::ST_FULL;
          end else begin
            count_d = count_q + 1'b1;
          end
        end
        ils_pkg::OP_READ: begin
          if (pos_ok) begin
            out_data_d.result_value = sel_entry;
          end else begin
            out_data_d.status = ils_pkg::ST_ABSENT;
          end
        end
        ils_pkg::OP_REMOVE: begin
          if (pos_ok) begin
            out_data_d.result_value = sel_entry;
            count_d = count_q - 1'b1;
          end else begin
            out_data_d.status = ils_pkg::ST_ABSENT;
          end
        end
        default: begin
          count_d = '0;
        end
      endcase
      out_data_d.entry_count = ils_pkg::EntryW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_cell.sv =====
`default_nettype none

module ils_cell (
  input  wire                                     clk_i,
  input  wire ils_pkg::cell_ctrl_t                ctrl_i,
  input  wire logic signed [ils_pkg::ValueW-1:0]  load_value_i,
  input  wire logic signed [ils_pkg::ValueW-1:0]  next_entry_i,
  output logic signed [ils_pkg::ValueW-1:0]       entry_o
);

  logic signed [ils_pkg::ValueW-1:0] entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_value_i;
    end else if (ctrl_i.shift) begin
      // take the neighbour's entry, closing the gap
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ils_checker.sv =====
`default_nettype none

module ils_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input wire ils_pkg::in_t   in_data_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input wire ils_pkg::out_t  out_data_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // every taken item gives a result in the next cycle
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after an accepted item");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ils_pkg::ST_FULL
    |-> out_data_o.entry_count == ils_pkg::EntryW'(ils_pkg::Capacity))
    else $error("full reported below capacity");

  a_absent_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ils_pkg::ST_ABSENT
    |-> out_data_o.result_value == '0)
    else $error("missing position returned a value");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= ils_pkg::EntryW'(ils_pkg::Capacity))
    else $error("entry count above capacity");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
